// ===== design/phase_vocoder_phase_propagation_assert.svh =====
// Assertion macros shared by the phase propagation RTL.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef PHASE_VOCODER_PHASE_PROPAGATION_ASSERT_SVH
`define PHASE_VOCODER_PHASE_PROPAGATION_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PVPP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("pvpp: assertion failed");
`define PVPP_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("pvpp: forbidden condition seen");
`else
`define PVPP_ASSERT(lbl, prop)
`define PVPP_ASSERT_NEVER(lbl, cond)
`endif
`endif

// ===== design/pvpp_pkg.sv =====
// Constants for the phase vocoder phase propagation block.
// CORDIC angle table, gain compensation and fixed field widths; no dependencies.
package pvpp_pkg;

  localparam int CordicSteps = 16;
  localparam int BinW        = 10;
  localparam int AhW         = 11;
  localparam int ShW         = 13;
  localparam int RatioW      = ShW + 16;
  localparam int PhaseW      = 16;
  localparam int OutW        = 17;

  localparam logic [29:0] InvGainQ30 = 30'd652032874;

  localparam logic [31:0] AtanTurns [CordicSteps] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C
  };

endpackage

// ===== design/phase_vocoder_phase_propagation.sv =====
// Phase vocoder phase propagation: polar split, phase advance, rebuild.
// Depends on pvpp_pkg and phase_vocoder_phase_propagation_assert.svh.
//
// Usage:
//   Bins enter on the s_ stream (one item = one complex bin with its bin
//   index; s_tuser flags the first frame) and leave on the m_ stream, one
//   result item per input item, in order. The APB port holds the analysis
//   and synthesis hop registers; pready is always high.
//   The pipeline takes one item per cycle while s_tready is high. The
//   accepting edge loads the first of 17 vectoring CORDIC stages, and
//   three stages of magnitude scaling, phase unwrapping and state update,
//   17 rotating CORDIC stages and the output register follow.
//   Per-bin state lives in two synchronous memories. The previous phase is
//   read and rewritten in the same cycle; the synthesis phase is read as an
//   item enters stage C and written back as it leaves it, and a one-deep
//   forward covers a bin that repeats on consecutive items.
//   After reset a clearing pass zeroes both memories, one entry per cycle,
//   over all BIN_COUNT entries; s_tready stays low until it ends. After a hop
//   register write, a bit-serial divider forms the stretch ratio, and
//   s_tready stays low meanwhile.
//   When the receiver stalls, the whole pipeline holds and s_tready drops
//   only while a result waits in the output register.
module phase_vocoder_phase_propagation #(
  parameter int FFT_POINTS = 1024,
  parameter int BIN_COUNT  = 513
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // bin_real [15:0], bin_imag [31:16], bin_index [41:32], zero [47:42]
  input  logic [47:0] s_tdata,
  // first_frame [0]
  input  logic        s_tuser,
  input  logic        s_tvalid,
  output logic        s_tready,
  // out_real [16:0], out_imag [33:17], out_bin [43:34], zero [47:44]
  output logic [47:0] m_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pvpp_pkg::*;

  localparam int AW  = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
  localparam int CW  = (AW > BinW) ? AW : BinW;
  localparam int Sh  = 16 - $clog2(FFT_POINTS);
  localparam int XW  = 36;
  localparam int ZW  = 34;
  localparam int NS  = CordicSteps;

  // ---------------------------------------------------------------- config
  logic [AhW-1:0]    ah_q;
  logic [ShW-1:0]    sh_q;
  logic [RatioW-1:0] ratio_q;
  logic              cfg_wr;
  logic [AhW-1:0]    ah_eff;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = paddr[2] ? {19'd0, sh_q} : {21'd0, ah_q};
  assign ah_eff = (ah_q == '0) ? AhW'(1) : ah_q;

  // Restoring divider: (synthesis_hop << 16) / analysis_hop, one bit a cycle.
  logic              div_load_q, div_run_q;
  logic [4:0]        div_cnt_q;
  logic [AhW-1:0]    div_rem_q, div_den_q;
  logic [RatioW-1:0] div_quo_q;
  logic [AhW:0]      div_t;
  logic              div_ge;
  logic              div_busy;

  assign div_t    = {div_rem_q, div_quo_q[RatioW-1]};
  assign div_ge   = div_t >= {1'b0, div_den_q};
  assign div_busy = div_load_q | div_run_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ah_q       <= AhW'(256);
      sh_q       <= ShW'(256);
      ratio_q    <= RatioW'(65536);
      div_load_q <= 1'b0;
      div_run_q  <= 1'b0;
      div_cnt_q  <= '0;
    end else begin
      div_load_q <= 1'b0;
      if (cfg_wr) begin
        if (paddr[2]) sh_q <= pwdata[ShW-1:0];
        else          ah_q <= pwdata[AhW-1:0];
        div_load_q <= 1'b1;
      end
      if (div_load_q) begin
        div_run_q <= 1'b1;
        div_cnt_q <= '0;
      end else if (div_run_q) begin
        div_cnt_q <= div_cnt_q + 5'd1;
        if (div_cnt_q == 5'(RatioW - 1)) begin
          div_run_q <= 1'b0;
          ratio_q   <= {div_quo_q[RatioW-2:0], div_ge};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_load_q) begin
      div_rem_q <= '0;
      div_den_q <= ah_eff;
      div_quo_q <= {sh_q, 16'd0};
    end else if (div_run_q) begin
      div_rem_q <= div_ge ? AhW'(div_t - {1'b0, div_den_q}) : div_t[AhW-1:0];
      div_quo_q <= {div_quo_q[RatioW-2:0], div_ge};
    end
  end

  // ---------------------------------------------------------- clearing pass
  logic          clr_busy_q;
  logic [AW-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_q      <= '0;
    end else if (clr_busy_q) begin
      clr_q <= clr_q + AW'(1);
      if (clr_q == AW'(BIN_COUNT - 1)) clr_busy_q <= 1'b0;
    end
  end

  // ------------------------------------------------------------- handshake
  logic en, acc, vld_o_q;

  assign en       = !vld_o_q | m_tready;
  assign s_tready = en & !clr_busy_q & !div_busy;
  assign acc      = s_tvalid & s_tready;

  // ------------------------------------------------------ vectoring CORDIC
  logic              vv_q  [NS+1];
  logic [BinW-1:0]   vk_q  [NS+1];
  logic              vf_q  [NS+1];
  logic              vs_q  [NS+1];
  logic              vzr_q [NS+1];
  logic signed [XW-1:0] vx_q [NS+1];
  logic signed [XW-1:0] vy_q [NS+1];
  logic [31:0]          vz_q [NS+1];
  logic signed [XW-1:0] vx_n [NS];
  logic signed [XW-1:0] vy_n [NS];
  logic [31:0]          vz_n [NS];

  logic signed [XW-1:0] in_x, in_y;
  logic [CW-1:0]        in_k;

  assign in_x = {{4{s_tdata[15]}}, s_tdata[15:0], 16'd0};
  assign in_y = {{4{s_tdata[31]}}, s_tdata[31:16], 16'd0};
  assign in_k = CW'(s_tdata[41:32]);

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      if (!vy_q[i][XW-1]) begin
        vx_n[i] = vx_q[i] + (vy_q[i] >>> i);
        vy_n[i] = vy_q[i] - (vx_q[i] >>> i);
        vz_n[i] = vz_q[i] + AtanTurns[i];
      end else begin
        vx_n[i] = vx_q[i] - (vy_q[i] >>> i);
        vy_n[i] = vy_q[i] + (vx_q[i] >>> i);
        vz_n[i] = vz_q[i] - AtanTurns[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= NS; i++) vv_q[i] <= 1'b0;
    end else if (en) begin
      vv_q[0] <= acc;
      for (int i = 0; i < NS; i++) vv_q[i+1] <= vv_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vk_q[0]  <= s_tdata[41:32];
      vf_q[0]  <= s_tuser;
      vs_q[0]  <= in_k < CW'(BIN_COUNT);
      vzr_q[0] <= (s_tdata[31:0] == 32'd0);
      if (in_x[XW-1]) begin
        vx_q[0] <= -in_x;
        vy_q[0] <= -in_y;
        vz_q[0] <= 32'h80000000;
      end else begin
        vx_q[0] <= in_x;
        vy_q[0] <= in_y;
        vz_q[0] <= 32'd0;
      end
      for (int i = 0; i < NS; i++) begin
        vk_q[i+1]  <= vk_q[i];
        vf_q[i+1]  <= vf_q[i];
        vs_q[i+1]  <= vs_q[i];
        vzr_q[i+1] <= vzr_q[i];
        vx_q[i+1]  <= vx_n[i];
        vy_q[i+1]  <= vy_n[i];
        vz_q[i+1]  <= vz_n[i];
      end
    end
  end

  // ------------------------------------------- stage A: phase, prev memory
  logic [PhaseW-1:0] prev_mem [BIN_COUNT];
  logic [PhaseW-1:0] synth_mem [BIN_COUNT];

  logic [31:0]          pa_round;
  logic [PhaseW-1:0]    pa_phase;
  logic signed [XW-1:0] pa_x;
  logic [31:0]          pa_omega;
  logic [AW-1:0]        pa_addr;
  logic [CW-1:0]        pa_kext;

  assign pa_round = vz_q[NS] + 32'h8000;
  assign pa_phase = vzr_q[NS] ? '0 : pa_round[31:16];
  assign pa_x     = (vzr_q[NS] || vx_q[NS][XW-1]) ? '0 : vx_q[NS];
  assign pa_omega = (32'(vk_q[NS]) * 32'(ah_eff)) << Sh;
  assign pa_kext  = CW'(vk_q[NS]);
  assign pa_addr  = pa_kext[AW-1:0];

  logic              va_q, sa_q, fa_q;
  logic [BinW-1:0]   ka_q;
  logic [PhaseW-1:0] pha_q, prd_q;
  logic [31:0]       oma_q;
  logic [46:0]       mlo_a_q;
  logic [17:0]       xhi_a_q;

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      prev_mem[clr_q] <= '0;
    end else if (en && vv_q[NS] && vs_q[NS]) begin
      prev_mem[pa_addr] <= pa_phase;
    end
    if (en) begin
      prd_q   <= prev_mem[pa_addr];
      ka_q    <= vk_q[NS];
      sa_q    <= vs_q[NS];
      fa_q    <= vf_q[NS];
      pha_q   <= pa_phase;
      oma_q   <= pa_omega;
      mlo_a_q <= 47'(pa_x[16:0]) * 47'(InvGainQ30);
      xhi_a_q <= pa_x[XW-2:17];
    end
  end

  // ------------------------------------------- stage B: magnitude, true_q
  logic [65:0]       pb_sum;
  logic [PhaseW-1:0] pb_prev, pb_delta;
  logic [31:0]       pb_true;

  assign pb_sum   = (66'(xhi_a_q) * 66'(InvGainQ30)) << 17;
  assign pb_prev  = (fa_q || !sa_q) ? '0 : prd_q;
  assign pb_delta = pha_q - pb_prev - oma_q[15:0];
  assign pb_true  = oma_q + {{16{pb_delta[15]}}, pb_delta};

  logic              vb_q, sb_q, fb_q;
  logic [BinW-1:0]   kb_q;
  logic [31:0]       magb_q, trueb_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      kb_q    <= ka_q;
      sb_q    <= sa_q;
      fb_q    <= fa_q;
      magb_q  <= 32'((pb_sum + 66'(mlo_a_q)) >> 30);
      trueb_q <= pb_true;
    end
  end

  // ------------------------------------ stage C: step, synth memory update
  logic [31:0]   pc_prod;
  logic [CW-1:0] pc_kext;
  logic [AW-1:0] pc_addr;

  assign pc_prod = trueb_q * 32'(ratio_q);
  assign pc_kext = CW'(kb_q);
  assign pc_addr = pc_kext[AW-1:0];

  logic              vc_q, sc_q, fc_q, hit_q;
  logic [BinW-1:0]   kc_q;
  logic [PhaseW-1:0] stepc_q, srd_q, fwd_q;
  logic [45:0]       mlo_c_q;
  logic [15:0]       mhi_c_q;

  logic [PhaseW-1:0] cc_old, cc_new;
  logic [CW-1:0]     cc_kext;
  logic [AW-1:0]     cc_addr;
  logic [61:0]       cc_sum;
  logic signed [XW-1:0] cc_x0;
  logic [31:0]       cc_a, cc_af;
  logic              cc_flip;

  assign cc_old  = (fc_q || !sc_q) ? '0 : (hit_q ? fwd_q : srd_q);
  assign cc_new  = cc_old + stepc_q;
  assign cc_kext = CW'(kc_q);
  assign cc_addr = cc_kext[AW-1:0];
  assign cc_sum  = ((62'(mhi_c_q) * 62'(InvGainQ30)) << 16) + 62'(mlo_c_q);
  assign cc_x0   = XW'(cc_sum[61:30]);
  assign cc_a    = {cc_new, 16'd0};
  assign cc_flip = cc_a[30] ^ cc_a[31];
  assign cc_af   = cc_flip ? (cc_a - 32'h80000000) : cc_a;

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      synth_mem[clr_q] <= '0;
    end else if (en && vc_q && sc_q) begin
      synth_mem[cc_addr] <= cc_new;
    end
    if (en) begin
      srd_q   <= synth_mem[pc_addr];
      fwd_q   <= cc_new;
      kc_q    <= kb_q;
      sc_q    <= sb_q;
      fc_q    <= fb_q;
      stepc_q <= pc_prod[31:16];
      mlo_c_q <= 46'(magb_q[15:0]) * 46'(InvGainQ30);
      mhi_c_q <= magb_q[31:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q  <= 1'b0;
      vb_q  <= 1'b0;
      vc_q  <= 1'b0;
      hit_q <= 1'b0;
    end else if (en) begin
      va_q  <= vv_q[NS];
      vb_q  <= va_q;
      vc_q  <= vb_q;
      hit_q <= vb_q && vc_q && sc_q && (kc_q == kb_q);
    end
  end

  // ------------------------------------------------------- rotating CORDIC
  logic                 rv_q [NS+1];
  logic [BinW-1:0]      rk_q [NS+1];
  logic signed [XW-1:0] rx_q [NS+1];
  logic signed [XW-1:0] ry_q [NS+1];
  logic signed [ZW-1:0] rz_q [NS+1];
  logic signed [XW-1:0] rx_n [NS];
  logic signed [XW-1:0] ry_n [NS];
  logic signed [ZW-1:0] rz_n [NS];

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      if (!rz_q[i][ZW-1]) begin
        rx_n[i] = rx_q[i] - (ry_q[i] >>> i);
        ry_n[i] = ry_q[i] + (rx_q[i] >>> i);
        rz_n[i] = rz_q[i] - $signed({2'b00, AtanTurns[i]});
      end else begin
        rx_n[i] = rx_q[i] + (ry_q[i] >>> i);
        ry_n[i] = ry_q[i] - (rx_q[i] >>> i);
        rz_n[i] = rz_q[i] + $signed({2'b00, AtanTurns[i]});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= NS; i++) rv_q[i] <= 1'b0;
    end else if (en) begin
      rv_q[0] <= vc_q;
      for (int i = 0; i < NS; i++) rv_q[i+1] <= rv_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rk_q[0] <= kc_q;
      rx_q[0] <= cc_flip ? -cc_x0 : cc_x0;
      ry_q[0] <= '0;
      rz_q[0] <= ZW'($signed(cc_af));
      for (int i = 0; i < NS; i++) begin
        rk_q[i+1] <= rk_q[i];
        rx_q[i+1] <= rx_n[i];
        ry_q[i+1] <= ry_n[i];
        rz_q[i+1] <= rz_n[i];
      end
    end
  end

  // --------------------------------------------------------- output stage
  function automatic logic [OutW-1:0] to_field(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] r;
    r = (v + XW'(32768)) >>> 16;
    if (r > XW'(65535))       to_field = 17'h0FFFF;
    else if (r < -XW'(65536)) to_field = 17'h10000;
    else                      to_field = r[OutW-1:0];
  endfunction

  logic [OutW-1:0] ore_q, oim_q;
  logic [BinW-1:0] ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_o_q <= 1'b0;
    else if (en) vld_o_q <= rv_q[NS];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ore_q <= to_field(rx_q[NS]);
      oim_q <= to_field(ry_q[NS]);
      ok_q  <= rk_q[NS];
    end
  end

  assign m_tvalid = vld_o_q;
  assign m_tdata  = {4'd0, ok_q, oim_q, ore_q};

  // ------------------------------------------------------------ assertions
`include "phase_vocoder_phase_propagation_assert.svh"

  `PVPP_ASSERT(a_fwd_needs_item, hit_q |-> vc_q)
  `PVPP_ASSERT_NEVER(a_clear_with_item, clr_busy_q && (vc_q || vv_q[NS]))
  `PVPP_ASSERT_NEVER(a_accept_while_div, div_busy && acc)
  `PVPP_ASSERT(a_clear_in_range, clr_busy_q |-> (clr_q <= AW'(BIN_COUNT - 1)))

endmodule

// ===== verif/phase_vocoder_phase_propagation_tb.sv =====
// Self-checking bench for the phase vocoder phase propagation block.
// Depends on pvpp_pkg and the phase_vocoder_phase_propagation RTL only.
`timescale 1ns / 1ps

module phase_vocoder_phase_propagation_tb;
  import pvpp_pkg::*;

  localparam int FftPoints = 1024;
  localparam int BinCount  = 513;
  localparam logic [2:0] AddrAnalysisHop  = 3'd0;
  localparam logic [2:0] AddrSynthesisHop = 3'd4;

  typedef struct packed {
    logic              first_frame;
    logic [BinW-1:0]   bin_index;
    logic signed [15:0] bin_imag;
    logic signed [15:0] bin_real;
  } bin_item_t;

  typedef struct packed {
    logic [BinW-1:0]    out_bin;
    logic signed [OutW-1:0] out_imag;
    logic signed [OutW-1:0] out_real;
  } rebuilt_bin_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [47:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] m_tdata;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  phase_vocoder_phase_propagation #(.FFT_POINTS(FftPoints), .BIN_COUNT(BinCount)) uut (
    .clk_i, .rst_ni, .s_tdata, .s_tuser, .s_tvalid, .s_tready,
    .m_tdata, .m_tvalid, .m_tready,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #2 clk_i = ~clk_i;

  // Predictor state: hop registers, the derived ratio and both per-bin phase tables.
  logic [AhW-1:0]    ana_hop_q;
  logic [ShW-1:0]    syn_hop_q;
  logic [63:0]       stretch_ratio;
  logic [15:0]       prev_phase_tbl  [BinCount];
  logic [15:0]       synth_phase_tbl [BinCount];

  bin_item_t    pending_bins[$];
  rebuilt_bin_t expected_bins[$];
  int  sender_idle_pct, receiver_idle_pct;
  int  errors = 0;
  int  bins_sent = 0, bins_checked = 0;
  bit  hold_receiver = 1'b0;

  function automatic longint shr_arith(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint sign16(longint v);
    return longint'(signed'(v[15:0]));
  endfunction

  function automatic void update_ratio();
    longint ah;
    ah = (ana_hop_q == 0) ? 1 : ana_hop_q;
    stretch_ratio = (64'(syn_hop_q) << 16) / ah;
  endfunction

  // Vectoring CORDIC: complex bin to Q16 turn phase and Q16 magnitude.
  function automatic void split_polar(input longint re, input longint im,
                                      output logic [15:0] ph, output longint mag);
    longint x, y, nx, ny;
    logic [31:0] z;
    x = re * 65536;
    y = im * 65536;
    z = 32'h0;
    if (re == 0 && im == 0) begin
      ph = '0;
      mag = 0;
      return;
    end
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h80000000;
    end
    for (int i = 0; i < CordicSteps; i++) begin
      if (y >= 0) begin
        nx = x + shr_arith(y, i);
        ny = y - shr_arith(x, i);
        z = z + AtanTurns[i];
      end else begin
        nx = x - shr_arith(y, i);
        ny = y + shr_arith(x, i);
        z = z - AtanTurns[i];
      end
      x = nx;
      y = ny;
    end
    z = z + 32'h8000;
    ph = z[31:16];
    mag = ((x < 0 ? 0 : x) * longint'(InvGainQ30)) >>> 30;
  endfunction

  function automatic logic [OutW-1:0] round_sat(longint v);
    longint r;
    r = shr_arith(v + 32768, 16);
    if (r > 65535) r = 65535;
    if (r < -65536) r = -65536;
    return r[OutW-1:0];
  endfunction

  // Rotating CORDIC: magnitude and phase back to a rounded, saturated bin.
  function automatic void build_rect(input longint mag, input logic [15:0] ph,
                                     output logic [OutW-1:0] re,
                                     output logic [OutW-1:0] im);
    longint x, y, z, nx, ny;
    logic [31:0] a, t;
    x = (mag * longint'(InvGainQ30)) >>> 30;
    y = 0;
    a = {ph, 16'h0};
    t = a + 32'h40000000;
    if (t[31]) begin
      x = -x;
      a = a - 32'h80000000;
    end
    z = longint'(signed'(a));
    for (int i = 0; i < CordicSteps; i++) begin
      if (z >= 0) begin
        nx = x - shr_arith(y, i);
        ny = y + shr_arith(x, i);
        z = z - longint'(AtanTurns[i]);
      end else begin
        nx = x + shr_arith(y, i);
        ny = y - shr_arith(x, i);
        z = z + longint'(AtanTurns[i]);
      end
      x = nx;
      y = ny;
    end
    re = round_sat(x);
    im = round_sat(y);
  endfunction

  function automatic rebuilt_bin_t propagate_bin(bin_item_t b);
    rebuilt_bin_t r;
    logic [15:0] ph, prev, synth;
    longint mag, k, ah, omega, true_q, step;
    bit stored;
    k = b.bin_index;
    stored = k < BinCount;
    ah = (ana_hop_q == 0) ? 1 : ana_hop_q;
    prev = '0;
    synth = '0;
    if (stored && !b.first_frame) begin
      prev = prev_phase_tbl[k];
      synth = synth_phase_tbl[k];
    end
    split_polar(longint'(b.bin_real), longint'(b.bin_imag), ph, mag);
    omega = ((k * ah) << 16) / FftPoints;
    true_q = omega + sign16(longint'(ph) - longint'(prev) - omega);
    step = (true_q * longint'(stretch_ratio)) >>> 16;
    synth = synth + step[15:0];
    if (stored) begin
      prev_phase_tbl[k] = ph;
      synth_phase_tbl[k] = synth;
    end
    build_rect(mag, synth, r.out_real, r.out_imag);
    r.out_bin = b.bin_index;
    return r;
  endfunction

  // Driver: offers the oldest pending bin, with random gaps at the sender's rate.
  always @(posedge clk_i) begin
    if (s_tvalid && s_tready) begin
      expected_bins.push_back(propagate_bin(bin_item_t'({s_tuser, s_tdata[41:0]})));
      bins_sent++;
    end
    if ((!s_tvalid || s_tready) && rst_ni) begin
      if (s_tvalid && s_tready) void'(pending_bins.pop_front());
      if (pending_bins.size() > 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, pending_bins[0].bin_index, pending_bins[0].bin_imag,
                     pending_bins[0].bin_real};
        s_tuser  <= pending_bins[0].first_frame;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result item against the oldest expectation.
  always @(posedge clk_i) begin
    rebuilt_bin_t got, want;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[43:0];
        if (expected_bins.size() == 0) begin
          $display("%0t: unexpected result item %h", $time, got);
          errors++;
        end else begin
          want = expected_bins.pop_front();
          if (got.out_real !== want.out_real || got.out_imag !== want.out_imag ||
              got.out_bin !== want.out_bin) begin
            $display("%0t: mismatch expected re %0d im %0d bin %0d, got re %0d im %0d bin %0d",
                     $time, want.out_real, want.out_imag, want.out_bin,
                     got.out_real, got.out_imag, got.out_bin);
            errors++;
          end
          bins_checked++;
        end
      end
      m_tready <= !hold_receiver && ($urandom_range(99, 0) >= receiver_idle_pct);
    end
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == AddrAnalysisHop) ana_hop_q = data[AhW-1:0];
    else syn_hop_q = data[ShW-1:0];
    update_ratio();
  endtask

  // Waits until every bin has gone in and every result has come back.
  task automatic drain_pipeline();
    wait (pending_bins.size() == 0 && !s_tvalid);
    wait (expected_bins.size() == 0);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic queue_bin(input logic signed [15:0] re, input logic signed [15:0] im,
                           input logic [BinW-1:0] k, input logic first);
    bin_item_t b;
    b.bin_real = re; b.bin_imag = im; b.bin_index = k; b.first_frame = first;
    pending_bins.push_back(b);
  endtask

  // One frame of bins over a small span; about one bin in ten takes a random index and first flag.
  task automatic queue_frame(input int lo, input int hi, input bit first);
    for (int k = lo; k <= hi; k++) begin
      if ($urandom_range(9, 0) == 0)
        queue_bin(16'($urandom), 16'($urandom), BinW'($urandom_range(1023, 0)),
                  1'($urandom_range(1, 0)));
      else
        queue_bin(16'($urandom), 16'($urandom), k[BinW-1:0], first);
    end
  endtask

  task automatic random_phase(input int n_items, input int snd, input int rcv);
    int lo;
    sender_idle_pct = snd;
    receiver_idle_pct = rcv;
    lo = $urandom_range(BinCount - 20, 0);
    queue_frame(lo, lo + 15, 1'b1);
    while (n_items > 0) begin
      if ($urandom_range(7, 0) == 0) lo = $urandom_range(BinCount - 20, 0);
      queue_frame(lo, lo + 15, $urandom_range(15, 0) == 0);
      n_items -= 16;
      wait (pending_bins.size() < 40);
    end
  endtask

  initial begin
    ana_hop_q = 11'd256;
    syn_hop_q = 13'd256;
    update_ratio();
    foreach (prev_phase_tbl[i]) begin
      prev_phase_tbl[i] = '0;
      synth_phase_tbl[i] = '0;
    end
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes, zero bin, repeated bins, edge indexes, and
    // indexes past the stored range at reset hop settings.
    queue_bin(16'sd0, 16'sd0, 10'd0, 1'b1);
    queue_bin(16'sh7FFF, 16'sh7FFF, 10'd1, 1'b1);
    queue_bin(16'sh8000, 16'sh8000, 10'd1, 1'b0);
    queue_bin(16'sh8000, 16'sh7FFF, 10'd1, 1'b0);
    queue_bin(16'sh7FFF, 16'sh8000, 10'd512, 1'b1);
    queue_bin(16'sd1, 16'sd0, 10'd512, 1'b0);
    queue_bin(16'sd0, -16'sd1, 10'd513, 1'b0);
    queue_bin(-16'sd1, 16'sd0, 10'd1023, 1'b0);
    queue_bin(16'sd100, 16'sd200, 10'd300, 1'b0);
    queue_bin(16'sd100, 16'sd200, 10'd300, 1'b0);
    queue_bin(16'sd0, 16'sd0, 10'd300, 1'b0);
    queue_bin(16'shAAAA, 16'sh5555, 10'h2AA, 1'b0);
    queue_bin(16'sh5555, 16'shAAAA, 10'h155, 1'b1);
    drain_pipeline();

    // Hop extremes, including the zero analysis hop and widths at full scale.
    apb_write(AddrAnalysisHop, 32'd0);
    apb_write(AddrSynthesisHop, 32'd4096);
    queue_frame(0, 7, 1'b1);
    queue_frame(0, 7, 1'b0);
    drain_pipeline();
    apb_write(AddrAnalysisHop, 32'h7FF);
    apb_write(AddrSynthesisHop, 32'h1FFF);
    queue_frame(505, 512, 1'b0);
    queue_frame(505, 512, 1'b0);
    drain_pipeline();

    // Random frames over two idling regimes at two hop settings, then a random hop setting.
    apb_write(AddrAnalysisHop, 32'd1024);
    apb_write(AddrSynthesisHop, 32'd1);
    random_phase(340, 38, 70);
    drain_pipeline();
    apb_write(AddrAnalysisHop, 32'd1);
    apb_write(AddrSynthesisHop, 32'd3000);
    random_phase(340, 70, 38);
    drain_pipeline();
    apb_write(AddrAnalysisHop, 32'($urandom_range(1024, 1)));
    apb_write(AddrSynthesisHop, 32'($urandom_range(4096, 1)));

    // The receiver stalls for a long stretch while the sender keeps offering.
    fork
      begin
        hold_receiver = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_receiver = 1'b0;
      end
      random_phase(340, 0, 0);
    join
    drain_pipeline();

    $display("Covered %0d bins sent, %0d results checked over six hop settings,",
             bins_sent, bins_checked);
    $display("including zero hop, bins past range and long output stalls.");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout after %0t", $time);
    $display("status: fail");
    $finish;
  end

endmodule
